// ===== hdl/gtii_pkg.sv =====
// ----------------------------------------------------------------------------
// Gradient texture integral image - shared package
// Register codes, sizes, and the item types passed between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package gtii_pkg;

    // configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'd1;

    localparam logic [CFG_W-1:0] COLS_RESET = 13'd640;
    localparam logic [CFG_W-1:0] ROWS_RESET = 13'd480;
    localparam int MIN_COLS = 6;
    localparam int MIN_ROWS = 2;

    // default size limits
    localparam int DEF_MAX_COLS = 4096;
    localparam int DEF_MAX_ROWS = 4096;

    // pixel / texture / sums
    localparam int PIX_W     = 8;
    localparam int TEX_MAX   = 255;
    localparam int PIX_LAG   = 4;     // texture pixel needs p[w] .. p[w+4]
    localparam int SUM_W     = 30;
    localparam int RUN_W     = 19;
    localparam int MAX_IDX_W = 12;    // line index at the largest column limit

    // queue depths
    localparam int JQ_DEPTH  = 4;
    localparam int OQ_DEPTH  = 4;
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

    // one or two texture pixels of one source pixel; the second is always
    // a zero pixel in the next texture column
    typedef struct packed {
        logic [PIX_W-1:0]     tex;
        logic [MAX_IDX_W-1:0] idx;
        logic                 top;
        logic                 pair;
        logic                 rend0;
        logic                 fend0;
        logic                 rend1;
        logic                 fend1;
    } t_job;

    typedef struct packed {
        logic [SUM_W-1:0] area;
        logic             rend;
        logic             fend;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/gtii_fifo.sv =====
// ----------------------------------------------------------------------------
// Gradient texture integral image - small register queue
// First-word-fall-through queue; head entry is shown while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module gtii_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [WIDTH-1:0]             i_wdata,
    input  wire logic                         i_pop,
    output logic      [WIDTH-1:0]             o_rdata,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count,
    output logic                              o_full,
    output logic                              o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gtii_front.sv =====
// ----------------------------------------------------------------------------
// Gradient texture integral image - front end
// Tracks source position, forms the gradient texture pixel and classifies
// each source pixel into zero, one or two texture pixels for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gtii_front
    import gtii_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [PIX_W-1:0] i_pixel,
    input  wire logic [CFG_W-1:0] i_image_cols,
    input  wire logic [CFG_W-1:0] i_image_rows,
    output logic                  o_job_valid,
    output t_job                  o_job
);

    localparam int CN_W = $clog2(MAX_COLS + 1);
    localparam int RN_W = $clog2(MAX_ROWS + 1);
    localparam int CW   = (CN_W > CFG_W) ? CN_W : CFG_W;
    localparam int RW   = (RN_W > CFG_W) ? RN_W : CFG_W;
    localparam int SC_W = $clog2(MAX_COLS);
    localparam int SR_W = $clog2(MAX_ROWS);
    localparam int TC_W = $clog2(MAX_COLS / 2 + 1);

    logic [PIX_W-1:0] r_recent [4];
    logic [SC_W-1:0]  r_scol;
    logic [SR_W-1:0]  r_srow;
    logic [TC_W-1:0]  r_tcol;

    logic [CW-1:0]    cfg_cols, cols, tex_w, scol_x, tcol_x;
    logic [RW-1:0]    cfg_rows, rows, tex_h, srow_x;
    logic             last_col, last_row, use_row, compute_px;
    logic             tcol_lt, tcol1_lt, first, second, frame_row;
    logic [PIX_W-1:0] d1, d2, dmax, tex;
    logic [PIX_W:0]   dbl;

    // clamp the frame size
    always_comb begin
        cfg_cols = CW'(i_image_cols);
        cfg_rows = RW'(i_image_rows);
        priority if (cfg_cols < CW'(MIN_COLS)) begin
            cols = CW'(MIN_COLS);
        end else if (cfg_cols > CW'(MAX_COLS)) begin
            cols = CW'(MAX_COLS);
        end else begin
            cols = cfg_cols;
        end
        priority if (cfg_rows < RW'(MIN_ROWS)) begin
            rows = RW'(MIN_ROWS);
        end else if (cfg_rows > RW'(MAX_ROWS)) begin
            rows = RW'(MAX_ROWS);
        end else begin
            rows = cfg_rows;
        end
    end

    assign tex_w  = cols >> 1;
    assign tex_h  = rows >> 1;
    assign scol_x = CW'(r_scol);
    assign srow_x = RW'(r_srow);
    assign tcol_x = CW'(r_tcol);

    // position decode
    assign last_col   = (scol_x + CW'(1)) >= cols;
    assign last_row   = (srow_x + RW'(1)) >= rows;
    assign use_row    = !r_srow[0] && ((srow_x + RW'(1)) < rows);
    assign tcol_lt    = tcol_x < tex_w;
    assign tcol1_lt   = (tcol_x + CW'(1)) < tex_w;
    assign compute_px = use_row && !r_scol[0] && (scol_x >= CW'(PIX_LAG))
                        && (scol_x < cols) && tcol_lt;
    assign first      = compute_px || (use_row && last_col && tcol_lt);
    assign second     = first && last_col && tcol1_lt;
    assign frame_row  = ((srow_x >> 1) + RW'(1)) == tex_h;

    // gradient texture: 2 * max(|p - p[-4]|, |p - p[-2]|), saturated
    always_comb begin
        d1   = (i_pixel > r_recent[3]) ? i_pixel - r_recent[3] : r_recent[3] - i_pixel;
        d2   = (i_pixel > r_recent[1]) ? i_pixel - r_recent[1] : r_recent[1] - i_pixel;
        dmax = (d1 > d2) ? d1 : d2;
        dbl  = {dmax, 1'b0};
        tex  = (dbl > (PIX_W+1)'(TEX_MAX)) ? PIX_W'(TEX_MAX) : dbl[PIX_W-1:0];
    end

    // request to the back end
    always_comb begin
        o_job_valid = i_accept && first;
        o_job.tex   = compute_px ? tex : '0;
        o_job.idx   = MAX_IDX_W'(r_tcol);
        o_job.top   = (r_srow == '0);
        o_job.pair  = second;
        o_job.rend0 = (tcol_x + CW'(1)) == tex_w;
        o_job.fend0 = ((tcol_x + CW'(1)) == tex_w) && frame_row;
        o_job.rend1 = (tcol_x + CW'(2)) == tex_w;
        o_job.fend1 = ((tcol_x + CW'(2)) == tex_w) && frame_row;
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scol <= '0;
            r_srow <= '0;
            r_tcol <= '0;
        end else if (i_accept) begin
            if (last_col) begin
                r_scol <= '0;
                r_tcol <= '0;
                r_srow <= last_row ? '0 : r_srow + 1'b1;
            end else begin
                r_scol <= r_scol + 1'b1;
                r_tcol <= r_tcol + TC_W'(compute_px);
            end
        end
    end

    // pixel history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_recent[i] <= '0;
            end
        end else if (i_accept) begin
            r_recent[3] <= r_recent[2];
            r_recent[2] <= r_recent[1];
            r_recent[1] <= r_recent[0];
            r_recent[0] <= i_pixel;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gtii_back.sv =====
// ----------------------------------------------------------------------------
// Gradient texture integral image - back end
// Two stages: issue (row sum, line memory read) and add (integral value,
// line memory write-back, result out). One texture pixel per clock while the result queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module gtii_back
    import gtii_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_job_valid,
    input  wire t_job                i_job,
    output logic                     o_job_pop,
    input  wire logic [OQ_CNT_W-1:0] i_out_count,
    output logic                     o_res_valid,
    output t_result                  o_res
);

    localparam int LINE_DEPTH = MAX_COLS / 2;
    localparam int IDX_W      = $clog2(LINE_DEPTH);

    // line memory of the previous integral row
    logic [SUM_W-1:0] r_line [LINE_DEPTH];
    logic [SUM_W-1:0] r_rdata;

    // issue stage state
    logic             r_sub;
    logic [RUN_W-1:0] r_sum;
    logic [IDX_W:0]   r_fill;     // entries below this were written

    // add stage
    logic             r_b_valid;
    logic [IDX_W-1:0] r_b_idx;
    logic [RUN_W-1:0] r_b_sum;
    logic             r_b_top, r_b_known, r_b_rend, r_b_fend;

    // last write, for a read of the same entry issued while that write was in the add stage
    logic             r_fw_valid;
    logic [IDX_W-1:0] r_fw_idx;
    logic [SUM_W-1:0] r_fw_data;

    logic             issue;
    logic [IDX_W-1:0] cur_idx;
    logic [PIX_W-1:0] cur_tex;
    logic [RUN_W-1:0] sum_in, sum_new;
    logic [SUM_W-1:0] above, area;

    // issue when the result queue has room for everything in flight
    assign issue     = i_job_valid
                       && ((i_out_count + OQ_CNT_W'(r_b_valid)) < OQ_CNT_W'(OQ_DEPTH));
    assign o_job_pop = issue && (r_sub || !i_job.pair);

    assign cur_idx = IDX_W'(i_job.idx) + IDX_W'(r_sub);
    assign cur_tex = r_sub ? '0 : i_job.tex;
    assign sum_in  = (cur_idx == '0) ? '0 : r_sum;
    assign sum_new = sum_in + RUN_W'(cur_tex);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub     <= 1'b0;
            r_sum     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= issue;
            if (issue) begin
                r_sub <= i_job.pair && !r_sub;
                r_sum <= sum_new;
            end
        end
    end

    // issue -> add payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_idx   <= cur_idx;
            r_b_sum   <= sum_new;
            r_b_top   <= i_job.top;
            r_b_known <= {1'b0, cur_idx} < r_fill;
            r_b_rend  <= r_sub ? i_job.rend1 : i_job.rend0;
            r_b_fend  <= r_sub ? i_job.fend1 : i_job.fend0;
        end
    end

    // add stage
    always_comb begin
        priority if (r_b_top) begin
            above = '0;
        end else if (r_fw_valid && (r_fw_idx == r_b_idx)) begin
            above = r_fw_data;
        end else if (r_b_known) begin
            above = r_rdata;
        end else begin
            above = '0;
        end
        area = above + SUM_W'(r_b_sum);
    end

    assign o_res_valid = r_b_valid;
    assign o_res.area  = area;
    assign o_res.rend  = r_b_rend;
    assign o_res.fend  = r_b_fend;

    // line memory: read at issue, write back from the add stage
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= r_line[cur_idx];
        end
        if (r_b_valid) begin
            r_line[r_b_idx] <= area;
        end
    end

    // write tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= r_b_valid;
            if (r_b_valid && (({1'b0, r_b_idx} + 1'b1) > r_fill)) begin
                r_fill <= {1'b0, r_b_idx} + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_fw_idx  <= r_b_idx;
            r_fw_data <= area;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gradient_texture_integral_image.sv =====
// ----------------------------------------------------------------------------
// Gradient texture integral image - top level
// Streams gray pixels in, streams summed-area values of the gradient
// texture out, both sides as queues.
// ----------------------------------------------------------------------------
// Accepts one source pixel per clock while full is low. Pixels of even
// source rows are turned into texture pixels by the front end and queued
// (4 entries) for the back end, which forms one integral value per clock
// while the result queue has room: a running row sum plus the value above
// from a single-port-write, single-port-read line memory of MAX_COLS/2
// words. A result passes through the request queue and the add stage
// register and then waits in a 4-entry result queue; at the end of a row
// up to two results come from one pixel, the second issued after the
// first. The line memory needs no clearing after reset: a write
// high-water mark makes unwritten entries read as zero. Write image_cols /
// image_rows only between frames for a clean frame.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_texture_integral_image
    import gtii_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // pixel input
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [PIX_W-1:0]     i_pixel,
    // results
    output logic                      empty,
    input  wire logic                 pop,
    output logic      [SUM_W-1:0]     o_area_sum,
    output logic                      o_row_end,
    output logic                      o_frame_end
);

    logic [CFG_W-1:0]    r_image_cols, r_image_rows;
    logic                accept;
    logic                job_valid, job_pop, jq_empty;
    t_job                job_in, job_out;
    logic [$bits(t_job)-1:0] jq_rdata;
    logic                res_valid;
    t_result             res_in, res_out;
    logic [$bits(t_result)-1:0] oq_rdata;
    logic [OQ_CNT_W-1:0] oq_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_cols <= COLS_RESET;
            r_image_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_COLS: r_image_cols <= i_cfg_data;
                REG_IMAGE_ROWS: r_image_rows <= i_cfg_data;
            endcase
        end
    end

    assign accept = push && !full;

    gtii_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_pixel      (i_pixel),
        .i_image_cols (r_image_cols),
        .i_image_rows (r_image_rows),
        .o_job_valid  (job_valid),
        .o_job        (job_in)
    );

    // request queue between front and back
    gtii_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JQ_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_wdata (job_in),
        .i_pop   (job_pop),
        .o_rdata (jq_rdata),
        .o_count (),
        .o_full  (full),
        .o_empty (jq_empty)
    );

    assign job_out = t_job'(jq_rdata);

    gtii_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!jq_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_out_count (oq_count),
        .o_res_valid (res_valid),
        .o_res       (res_in)
    );

    // result queue
    gtii_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OQ_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_wdata (res_in),
        .i_pop   (pop),
        .o_rdata (oq_rdata),
        .o_count (oq_count),
        .o_full  (),
        .o_empty (empty)
    );

    assign res_out     = t_result'(oq_rdata);
    assign o_area_sum  = res_out.area;
    assign o_row_end   = res_out.rend;
    assign o_frame_end = res_out.fend;

endmodule

`default_nettype wire
